@@ sv/plau_pkg.sv @@
// Shared types, constants and the linearisation table for the proximity
// linearizer / auto-zero unit. No dependencies.
`timescale 1ns / 1ps

package plau_pkg;

  localparam int CH_W   = 3;
  localparam int SMP_W  = 12;
  localparam int DIST_W = 16;
  localparam int HOLD_W = 8;

  localparam int CHANNELS_DEF     = 8;
  localparam int TABLE_POINTS_DEF = 11;
  localparam int TABLE_LEN        = 11;
  localparam int STEP_MM          = 10;

  localparam logic [DIST_W-1:0] OUT_OF_RANGE  = 16'hFFFF;
  localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 8'd25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEARCH,
    ST_DIVIDE,
    ST_EVENT
  } plau_state_t;

  // Converter value at 0, 10, ..., 100 mm, strictly decreasing.
  function automatic logic [SMP_W-1:0] lin_point(input logic [4:0] j);
    logic [SMP_W-1:0] v;
    unique case (j)
      5'd0:    v = 12'd3788;
      5'd1:    v = 12'd3548;
      5'd2:    v = 12'd857;
      5'd3:    v = 12'd474;
      5'd4:    v = 12'd296;
      5'd5:    v = 12'd205;
      5'd6:    v = 12'd153;
      5'd7:    v = 12'd113;
      5'd8:    v = 12'd84;
      5'd9:    v = 12'd65;
      5'd10:   v = 12'd53;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/plau_if.sv @@
// Handshake channel interfaces for the proximity linearizer: sample input,
// result output and holdoff configuration. Depends on plau_pkg.
`timescale 1ns / 1ps

interface plau_in_if;
  logic                        valid;
  logic                        ready;
  logic [plau_pkg::CH_W-1:0]   channel;
  logic [plau_pkg::SMP_W-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface plau_out_if;
  logic                        valid;
  logic                        ready;
  logic [plau_pkg::CH_W-1:0]   out_channel;
  logic [plau_pkg::DIST_W-1:0] distance_mm;
  logic [plau_pkg::SMP_W-1:0]  max_seen_out;
  logic                        send_event;

  modport source (output valid, output out_channel, output distance_mm,
                  output max_seen_out, output send_event, input ready);
  modport sink   (input valid, input out_channel, input distance_mm,
                  input max_seen_out, input send_event, output ready);
endinterface

interface plau_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [plau_pkg::HOLD_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/proximity_linearizer_autozero_unit.sv @@
// Sequence: the input transfer is registered; ST_LOAD updates the channel maximum and goes
// straight to ST_EVENT when the sample equals the channel maximum; otherwise the serial table
// search runs, and the 4-step interpolation divide follows when a point past the first is hit.
// Throughput: one item at a time; the next transfer is taken in the cycle after the result
// is loaded, and loading waits while a result is held and the receiver is not ready.
// Reset (rst, synchronous): maxima and holdoff counters clear, holdoff period 25.
`timescale 1ns / 1ps

module proximity_linearizer_autozero_unit #(
  parameter int CHANNELS     = plau_pkg::CHANNELS_DEF,
  parameter int TABLE_POINTS = plau_pkg::TABLE_POINTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  plau_in_if.sink       samples,
  plau_out_if.source    results,
  plau_cfg_if.sink      cfg
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int J_W   = $clog2(TABLE_POINTS);
  localparam int NPTS  = (TABLE_POINTS < plau_pkg::TABLE_LEN) ?
                         TABLE_POINTS : plau_pkg::TABLE_LEN;
  localparam logic [J_W-1:0] J_LAST = J_W'(NPTS - 1);

  plau_pkg::plau_state_t state, state_next;

  logic [plau_pkg::SMP_W-1:0]  max_seen [CHANNELS];
  logic [plau_pkg::HOLD_W-1:0] hold_cnt [CHANNELS];
  logic [plau_pkg::HOLD_W-1:0] period;

  logic [plau_pkg::CH_W-1:0]   ch_r;
  logic [plau_pkg::SMP_W-1:0]  smp_r;
  logic                        bad;
  logic [plau_pkg::SMP_W-1:0]  mx;
  logic [plau_pkg::SMP_W-1:0]  diff;
  logic [J_W-1:0]              j;
  logic [plau_pkg::SMP_W-1:0]  prev;
  logic [15:0]                 rem;
  logic [plau_pkg::SMP_W-1:0]  span;
  logic [3:0]                  quo;
  logic [1:0]                  k;
  logic [8:0]                  base;
  logic [plau_pkg::DIST_W-1:0] distance;

  logic [4:0]                  ch_ext;
  logic [IDX_W-1:0]            idx;
  logic [plau_pkg::SMP_W-1:0]  cur_max, new_max;
  logic [plau_pkg::SMP_W-1:0]  here;
  logic                        hit;
  logic [plau_pkg::SMP_W-1:0]  span_raw;
  logic [15:0]                 shifted;
  logic                        ge;
  logic [3:0]                  q_fin;
  logic                        fire;
  logic                        out_load;

  assign cfg.ready = 1'b1;

  assign ch_ext  = {2'b00, ch_r};
  assign idx     = ch_ext[IDX_W-1:0];
  assign cur_max = max_seen[idx];
  assign new_max = (cur_max < smp_r) ? smp_r : cur_max;
  assign here    = plau_pkg::lin_point(5'(j));
  assign hit     = (here <= diff);
  assign span_raw = prev - here;

  // Quotient stays below 10: diff lies under the previous point, so one
  // trial subtract per quotient bit, highest first.
  assign shifted = 16'(span) << k;
  assign ge      = (rem >= shifted);
  assign q_fin   = quo | (ge ? (4'b0001 << k) : 4'b0000);

  assign fire = !bad && ((distance != plau_pkg::OUT_OF_RANGE) || (hold_cnt[idx] == period));

  always_comb begin
    state_next = state;
    unique case (state)
      plau_pkg::ST_IDLE: begin
        if (samples.valid) state_next = plau_pkg::ST_LOAD;
      end
      plau_pkg::ST_LOAD: begin
        if (bad || (new_max == smp_r)) state_next = plau_pkg::ST_EVENT;
        else                            state_next = plau_pkg::ST_SEARCH;
      end
      plau_pkg::ST_SEARCH: begin
        if (hit) begin
          state_next = (j == '0) ? plau_pkg::ST_EVENT : plau_pkg::ST_DIVIDE;
        end else if (j == J_LAST) begin
          state_next = plau_pkg::ST_EVENT;
        end
      end
      plau_pkg::ST_DIVIDE: begin
        if (k == 2'd0) state_next = plau_pkg::ST_EVENT;
      end
      plau_pkg::ST_EVENT: begin
        if (!results.valid || results.ready) state_next = plau_pkg::ST_IDLE;
      end
      default: state_next = plau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    samples.ready = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      plau_pkg::ST_IDLE:  samples.ready = 1'b1;
      plau_pkg::ST_EVENT: out_load = !results.valid || results.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= plau_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        max_seen[c] <= '0;
        hold_cnt[c] <= '0;
      end
      period        <= plau_pkg::HOLDOFF_RESET;
      results.valid <= 1'b0;
    end else begin
      if (cfg.valid) period <= cfg.data;
      if (state == plau_pkg::ST_LOAD && !bad) max_seen[idx] <= new_max;
      if (out_load && !bad) begin
        hold_cnt[idx] <= fire ? '0 : hold_cnt[idx] + 8'd1;
      end
      if (out_load)           results.valid <= 1'b1;
      else if (results.ready) results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      ch_r  <= samples.channel;
      smp_r <= samples.sample;
      bad   <= ({2'b00, samples.channel} >= 5'(CHANNELS));
    end
    case (state)
      plau_pkg::ST_LOAD: begin
        mx       <= new_max;
        diff     <= new_max - smp_r;
        distance <= '0;
        j        <= '0;
      end
      plau_pkg::ST_SEARCH: begin
        prev <= here;
        j    <= j + 1'b1;
        if (hit) begin
          rem  <= 16'(plau_pkg::STEP_MM) * 16'(diff - here);
          span <= (span_raw == '0) ? 12'd1 : span_raw;
          quo  <= '0;
          k    <= 2'd3;
          base <= 9'(plau_pkg::STEP_MM) * 9'(j);
        end else if (j == J_LAST) begin
          distance <= plau_pkg::OUT_OF_RANGE;
        end
      end
      plau_pkg::ST_DIVIDE: begin
        if (ge) rem <= rem - shifted;
        quo <= q_fin;
        k   <= k - 2'd1;
        if (k == 2'd0) begin
          distance <= (16'(base) >= 16'(q_fin)) ? 16'(base) - 16'(q_fin) : '0;
        end
      end
      plau_pkg::ST_EVENT: begin
        if (out_load) begin
          results.out_channel  <= ch_r;
          results.distance_mm  <= bad ? '0 : distance;
          results.max_seen_out <= bad ? '0 : mx;
          results.send_event   <= fire;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // A withheld result is always an out-of-range one or an unknown channel.
  a_quiet_only_oor: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.send_event |->
      (results.distance_mm == plau_pkg::OUT_OF_RANGE) ||
      ({2'b00, results.out_channel} >= 5'(CHANNELS)))
    else $error("result withheld although in range");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.distance_mm != plau_pkg::OUT_OF_RANGE) |->
      (results.distance_mm <= 16'(plau_pkg::STEP_MM * (NPTS - 1))))
    else $error("interpolated distance beyond table span");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("second sample taken while one is in work");

  a_divide_digit: assert property (@(posedge clk) disable iff (rst)
    state == plau_pkg::ST_DIVIDE && k == 2'd0 |-> q_fin < 4'd10)
    else $error("interpolation fraction reached a full step");
`endif

endmodule

@@ tb/sv/tb_proximity_linearizer_autozero_unit.sv @@
// Testbench for proximity_linearizer_autozero_unit: drives directed and random
// samples, predicts every reading in SV and checks results in order.
// Depends on plau_pkg, plau_if and the unit RTL.
`timescale 1ns / 1ps

module tb_proximity_linearizer_autozero_unit;

  localparam int CH_W      = plau_pkg::CH_W;
  localparam int SMP_W     = plau_pkg::SMP_W;
  localparam int DIST_W    = plau_pkg::DIST_W;
  localparam int HOLD_W    = plau_pkg::HOLD_W;
  localparam int TABLE_LEN = plau_pkg::TABLE_LEN;
  localparam int STEP_MM   = plau_pkg::STEP_MM;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [DIST_W-1:0] distance;
    logic [SMP_W-1:0]  peak;
    logic              fire;
  } reading_t;

  localparam int NUM_CH = plau_pkg::CHANNELS_DEF;
  // Converter value at 0, 10, ..., 100 mm
  localparam int unsigned LIN_PTS [0:TABLE_LEN-1] =
    '{3788, 3548, 857, 474, 296, 205, 153, 113, 84, 65, 53};

  logic clk;
  logic rst;

  plau_in_if  samples_if ();
  plau_out_if results_if ();
  plau_cfg_if cfg_if ();

  proximity_linearizer_autozero_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // Predictor state
  logic [SMP_W-1:0]  peak_of [NUM_CH];
  logic [HOLD_W-1:0] holdoff_cnt [NUM_CH];
  logic [HOLD_W-1:0] holdoff_period;
  reading_t          pending_readings [$];

  int  mismatches = 0;
  int  burst_left = 10;
  bit  valid_high = 0;
  logic [7:0] stall_phase;
  int  stall_mode;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [DIST_W-1:0] distance_of(input logic [SMP_W-1:0] diff);
    int unsigned frac;
    if (diff == '0) return '0;
    for (int j = 0; j < TABLE_LEN; j++) begin
      if (LIN_PTS[j] <= diff) begin
        // at or beyond the first point the distance saturates at zero
        if (j == 0) return '0;
        frac = (STEP_MM * (diff - LIN_PTS[j])) / (LIN_PTS[j-1] - LIN_PTS[j]);
        return DIST_W'(STEP_MM * j - frac);
      end
    end
    return plau_pkg::OUT_OF_RANGE;
  endfunction

  task automatic predict_reading(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
    reading_t r;
    if (peak_of[ch] < smp) peak_of[ch] = smp;
    r.ch       = ch;
    r.peak     = peak_of[ch];
    r.distance = distance_of(peak_of[ch] - smp);
    r.fire     = (r.distance != plau_pkg::OUT_OF_RANGE) ||
                 (holdoff_cnt[ch] == holdoff_period);
    holdoff_cnt[ch] = r.fire ? '0 : holdoff_cnt[ch] + 1'b1;
    pending_readings.push_back(r);
  endtask

  task automatic lower_valid();
    if (valid_high) begin
      samples_if.valid <= 1'b0;
      valid_high = 0;
    end
  endtask

  // valid is left high after the transfer so back-to-back items need no re-raise
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
    samples_if.valid   <= 1'b1;
    samples_if.channel <= ch;
    samples_if.sample  <= smp;
    valid_high = 1;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    predict_reading(ch, smp);
  endtask

  task automatic pace_sender();
    if (burst_left == 0) begin
      lower_valid();
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_paced(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
    send_sample(ch, smp);
    pace_sender();
  endtask

  task automatic drain_results();
    lower_valid();
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_holdoff(input logic [HOLD_W-1:0] value);
    drain_results();
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    holdoff_period = value;
  endtask

  function automatic logic [SMP_W-1:0] pick_sample(input int ch);
    logic [SMP_W-1:0] m;
    int unsigned d;
    int unsigned seg;
    int k;
    m = peak_of[ch];
    k = $urandom_range(0, 99);
    if (k < 10) return SMP_W'($urandom_range(0, 4095));
    if (k < 18) return SMP_W'($urandom_range(m, 4095));
    if (k < 28) begin
      d = 0;
    end else if (k < 43) begin
      d = $urandom_range(1, 52);
    end else if (k < 88) begin
      seg = $urandom_range(1, TABLE_LEN - 1);
      d = $urandom_range(LIN_PTS[seg], LIN_PTS[seg-1] - 1);
    end else begin
      d = $urandom_range(3788, 4095);
    end
    if (d > m) return SMP_W'($urandom_range(0, 4095));
    return SMP_W'(m - d);
  endfunction

  task automatic send_near_peak(input int ch, input int n);
    for (int k = 0; k < n; k++)
      send_paced(CH_W'(ch), SMP_W'(peak_of[ch] - $urandom_range(1, 52)));
  endtask

  // Zero difference, saturation at the first point and its neighbour
  task automatic test_zero_and_extremes();
    send_paced(3'd0, 12'd4095);
    send_paced(3'd0, 12'd0);
    send_paced(3'd0, 12'd307);
    send_paced(3'd0, 12'd308);
    send_paced(3'd1, 12'd0);
    send_paced(3'd7, 12'hAAA);
    send_paced(3'd7, 12'h555);
    send_paced(3'd6, 12'd1);
  endtask

  // Every table point past the first hit exactly, plus the out-of-range edge
  task automatic test_table_points();
    send_paced(3'd2, 12'd4095);
    for (int j = 1; j < TABLE_LEN; j++)
      send_paced(3'd2, SMP_W'(4095 - LIN_PTS[j]));
    send_paced(3'd2, 12'd4095 - 12'd52);
    send_paced(3'd2, 12'd4094);
  endtask

  task automatic test_holdoff();
    // reset period first, then zero, then the top value
    send_paced(3'd3, 12'd4000);
    send_near_peak(3, 30);
    write_holdoff(8'd0);
    send_near_peak(3, 6);
    write_holdoff(8'd255);
    send_paced(3'd4, 12'd3000);
    send_near_peak(4, 260);
    // lower the period under the running count: counter wraps before firing
    send_paced(3'd5, 12'd3000);
    send_near_peak(5, 40);
    write_holdoff(8'd10);
    send_near_peak(5, 240);
  endtask

  task automatic run_random_phase(input logic [HOLD_W-1:0] period, input int n_items);
    int sent;
    int ch;
    int run_len;
    bit oor_run;
    logic [SMP_W-1:0] smp;
    write_holdoff(period);
    sent = 0;
    while (sent < n_items) begin
      ch      = $urandom_range(0, NUM_CH - 1);
      run_len = $urandom_range(1, 40);
      oor_run = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        if (oor_run && $urandom_range(0, 99) < 85 && peak_of[ch] > 52)
          smp = SMP_W'(peak_of[ch] - $urandom_range(1, 52));
        else
          smp = pick_sample(ch);
        send_paced(CH_W'(ch), smp);
        sent++;
      end
    end
  endtask

  task automatic test_random();
    run_random_phase(8'd1, 120);
    run_random_phase(8'd3, 120);
    run_random_phase(HOLD_W'($urandom_range(0, 255)), 120);
    run_random_phase(8'd254, 120);
    run_random_phase(8'd8, 120);
    run_random_phase(HOLD_W'(plau_pkg::HOLDOFF_RESET), 120);
  endtask

  // Receiver: fully ready, random or periodic stalls, switched each time the 8-bit stall_phase wraps
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      stall_phase      <= '0;
      stall_mode       <= 0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase == 8'hFF) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       results_if.ready <= 1'b1;
        1:       results_if.ready <= ($urandom_range(0, 3) != 0);
        default: results_if.ready <= (stall_phase[2:0] < 3'd3);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input reading_t want, input reading_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: exp ch=%0d dist=%0d peak=%0d ev=%0b, got ch=%0d dist=%0d peak=%0d ev=%0b",
               what, want.ch, want.distance, want.peak, want.fire,
               got.ch, got.distance, got.peak, got.fire);
  endtask

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      got.ch       = results_if.out_channel;
      got.distance = results_if.distance_mm;
      got.peak     = results_if.max_seen_out;
      got.fire     = results_if.send_event;
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_readings.pop_front();
        if (got.ch !== want.ch || got.distance !== want.distance ||
            got.peak !== want.peak || got.fire !== want.fire)
          report_mismatch("mismatch", want, got);
      end
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    samples_if.valid   = 1'b0;
    samples_if.channel = '0;
    samples_if.sample  = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.data        = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      peak_of[c]     = '0;
      holdoff_cnt[c] = '0;
    end
    holdoff_period = plau_pkg::HOLDOFF_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_zero_and_extremes();
    test_table_points();
    test_holdoff();
    test_random();

    drain_results();
    // quiet window: any stray result would show up here
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/plau_pkg.sv
sv/plau_if.sv
sv/proximity_linearizer_autozero_unit.sv
tb/sv/tb_proximity_linearizer_autozero_unit.sv
